// ===== hdl/rqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rqs_pkg: shared definitions of the priority ready queue scheduler
// Field widths, parameter defaults and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rqs_pkg;

    localparam int DEF_NUM_LEVELS = 32;
    localparam int DEF_NUM_TASKS  = 64;

    localparam int FUNC_W = 1;
    localparam int TASK_W = 6;
    localparam int PRI_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_READY = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_NEXT  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // capture the item and read tail and head stores
        logic link_rd;    // read the link of the selected head
        logic deq_wr;     // advance the head or empty the level
        logic enq_wr;     // append the task to its level
        logic clr_wr;     // clear the link of the appended task
        logic res_load;   // load the result register
        logic res_found;  // a task is returned with this result
    } t_rqs_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_next;     // the offered item asks for the next task
        logic in_range;    // the offered task and level are within bounds
        logic mask_empty;  // every level is empty
        logic out_free;    // the result register can take a new result
    } t_rqs_status;

endpackage

`default_nettype wire

// ===== hdl/rqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rqs_ctrl: sequencer of the priority ready queue scheduler
// One-hot state machine that steps each item through its memory reads and
// writes and issues commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_ctrl
    import rqs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_rqs_status i_status,
    output t_rqs_cmd         o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LINK = 6'b000010,
        S_DEQ  = 6'b000100,
        S_NONE = 6'b001000,
        S_ENQ  = 6'b010000,
        S_CLR  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.is_next) begin
                        n_state = i_status.mask_empty ? S_NONE : S_LINK;
                    end else begin
                        n_state = i_status.in_range ? S_ENQ : S_IDLE;
                    end
                end
            end
            S_LINK: begin
                o_cmd.link_rd = 1'b1;
                n_state       = S_DEQ;
            end
            S_DEQ: begin
                // The queue is only updated once the result has somewhere to go.
                if (i_status.out_free) begin
                    o_cmd.deq_wr    = 1'b1;
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_found = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_NONE: begin
                if (i_status.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ENQ: begin
                o_cmd.enq_wr = 1'b1;
                n_state      = S_CLR;
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/rqs_dpath.sv =====
// ----------------------------------------------------------------------------
// rqs_dpath: datapath of the priority ready queue scheduler
// Level bitmap, head, tail and link memories, the priority encoder and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_dpath
    import rqs_pkg::*;
#(
    parameter int NUM_LEVELS = DEF_NUM_LEVELS,
    parameter int NUM_TASKS  = DEF_NUM_TASKS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [TASK_W-1:0] i_task_id,
    input  wire logic [PRI_W-1:0]  i_priority_req,
    input  wire t_rqs_cmd          i_cmd,
    output t_rqs_status            o_status,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_found,
    output logic [TASK_W-1:0]      o_next_task
);

    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    // A link entry holds a valid flag above the index of the following task.
    logic [TW-1:0] head_mem [NUM_LEVELS];
    logic [TW-1:0] tail_mem [NUM_LEVELS];
    logic [TW:0]   link_mem [NUM_TASKS];

    logic [NUM_LEVELS-1:0] r_mask;
    logic [TW-1:0]         r_task;
    logic [LW-1:0]         r_pri;
    logic [LW-1:0]         r_level;
    logic [TW-1:0]         r_tail_q;
    logic [TW-1:0]         r_head_q;
    logic [TW:0]           r_link_q;
    logic                  r_out_valid;
    logic                  r_found;
    logic [TASK_W-1:0]     r_next_task;

    logic [LW-1:0] top_level;
    logic          head_we;
    logic [LW-1:0] head_wa;
    logic [TW-1:0] head_wd;
    logic          link_we;
    logic [TW-1:0] link_wa;
    logic [TW:0]   link_wd;

    // Highest set bit of the bitmap; the later, higher levels take precedence.
    always_comb begin
        top_level = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (r_mask[l]) begin
                top_level = LW'(l);
            end
        end
    end

    assign o_status.is_next    = (i_func == FUNC_NEXT);
    assign o_status.in_range   = (32'(i_priority_req) < 32'(NUM_LEVELS))
                              && (32'(i_task_id) < 32'(NUM_TASKS));
    assign o_status.mask_empty = (r_mask == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // Item capture with the tail and head reads, and the link read of the captured head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_task   <= TW'(i_task_id);
            r_pri    <= LW'(i_priority_req);
            r_level  <= top_level;
            r_tail_q <= tail_mem[LW'(i_priority_req)];
            r_head_q <= head_mem[top_level];
        end
        if (i_cmd.link_rd) begin
            r_link_q <= link_mem[r_head_q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cmd.deq_wr && !r_link_q[TW]) begin
            r_mask[r_level] <= 1'b0;
        end else if (i_cmd.enq_wr) begin
            r_mask[r_pri] <= 1'b1;
        end
    end

    always_comb begin
        head_we = 1'b0;
        head_wa = r_pri;
        head_wd = r_task;
        if (i_cmd.deq_wr && r_link_q[TW]) begin
            head_we = 1'b1;
            head_wa = r_level;
            head_wd = r_link_q[TW-1:0];
        end else if (i_cmd.enq_wr && !r_mask[r_pri]) begin
            head_we = 1'b1;
        end
    end

    // An append links the old tail to the task; the next step ends the task's
    // own link, so a task appended behind itself ends up with no successor.
    always_comb begin
        link_we = 1'b0;
        link_wa = r_task;
        link_wd = '0;
        if (i_cmd.enq_wr && r_mask[r_pri]) begin
            link_we = 1'b1;
            link_wa = r_tail_q;
            link_wd = {1'b1, r_task};
        end else if (i_cmd.clr_wr) begin
            link_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        if (i_cmd.enq_wr) begin
            tail_mem[r_pri] <= r_task;
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_found     <= i_cmd.res_found;
            r_next_task <= i_cmd.res_found ? TASK_W'(r_head_q) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_next_task = r_next_task;

endmodule

`default_nettype wire

// ===== hdl/priority_ready_queue_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top: bitmap priority ready queue
// One linked FIFO of task numbers per priority level and a bitmap of the
// levels in use; the highest non-empty level is served first.
//
//   Channel  Direction  Handshake              Payload
//   in       input      i_in_valid/o_in_ready  i_func, i_task_id, i_priority_req
//   out      output     o_out_valid/i_out_ready o_found, o_next_task
//
// A ready item steps through the accept, the append and the link clear. A
// next item steps through the accept, the link read and the dequeue, or to an
// empty result when no level is in use; the link read follows the head read.
// Of the queue storage only the bitmap is cleared by reset; no clearing pass is needed.
// A result waits in the output register while the next item is taken; a
// further result is held back until that register is emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue_scheduler_top
    import rqs_pkg::*;
#(
    parameter int NUM_LEVELS = DEF_NUM_LEVELS,
    parameter int NUM_TASKS  = DEF_NUM_TASKS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [TASK_W-1:0] i_task_id,
    input  wire logic [PRI_W-1:0]  i_priority_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_found,
    output logic [TASK_W-1:0]      o_next_task
);

    t_rqs_cmd    cmd;
    t_rqs_status status;

    rqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rqs_dpath #(
        .NUM_LEVELS (NUM_LEVELS),
        .NUM_TASKS  (NUM_TASKS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_func),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_found        (o_found),
        .o_next_task    (o_next_task)
    );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for the priority ready queue scheduler
// Ready and next items are driven through the input channel, and a shadow of
// the per-level task lists predicts every pick. Each returned result is
// compared with the oldest outstanding pick. The sender and the receiver both
// idle at random. At one point the receiver holds off for a long stretch, so
// that the block backs up.
// ----------------------------------------------------------------------------

module tb
    import rqs_pkg::*;
();

    localparam int LEVELS           = DEF_NUM_LEVELS;
    localparam int TASKS            = DEF_NUM_TASKS;
    localparam int RANDOM_PER_PHASE = 140;
    localparam int HOLD_CYCLES      = 400;
    localparam int MAX_GAP          = 20;

    typedef struct packed {
        logic              found;
        logic [TASK_W-1:0] task_no;
    } t_pick;

    // Shadow of the ready queue: level bitmap, per-level head and tail, and the
    // per-task link, plus a rough count of how often each task is waiting.
    class ready_queue_shadow;
        logic [LEVELS-1:0] level_busy;
        logic [TASK_W-1:0] head_of [LEVELS];
        logic [TASK_W-1:0] tail_of [LEVELS];
        bit                link_ok [TASKS];
        logic [TASK_W-1:0] link_to [TASKS];
        int unsigned       waiting_cnt [TASKS];
        t_pick             picks_due [$];
        int unsigned       faults;

        function new();
            level_busy = '0;
            faults     = 0;
            for (int t = 0; t < TASKS; t++) begin
                waiting_cnt[t] = 0;
            end
        endfunction

        function void take_request(logic [FUNC_W-1:0] func, logic [TASK_W-1:0] task_no,
                                   logic [PRI_W-1:0] pri);
            int    lvl;
            t_pick pick;
            if (func == FUNC_READY) begin
                if (pri >= LEVELS || task_no >= TASKS) begin
                    return;
                end
                if (level_busy[pri]) begin
                    link_ok[tail_of[pri]] = 1'b1;
                    link_to[tail_of[pri]] = task_no;
                    tail_of[pri] = task_no;
                end else begin
                    head_of[pri]    = task_no;
                    tail_of[pri]    = task_no;
                    level_busy[pri] = 1'b1;
                end
                // The appended task always ends its list, even when it was
                // already linked in somewhere.
                link_ok[task_no] = 1'b0;
                link_to[task_no] = '0;
                waiting_cnt[task_no]++;
            end else begin
                lvl = -1;
                for (int l = 0; l < LEVELS; l++) begin
                    if (level_busy[l]) begin
                        lvl = l;
                    end
                end
                if (lvl < 0) begin
                    pick = '{found: 1'b0, task_no: '0};
                end else begin
                    pick = '{found: 1'b1, task_no: head_of[lvl]};
                    if (link_ok[head_of[lvl]]) begin
                        head_of[lvl] = link_to[head_of[lvl]];
                    end else begin
                        level_busy[lvl] = 1'b0;
                    end
                    if (waiting_cnt[pick.task_no] != 0) begin
                        waiting_cnt[pick.task_no]--;
                    end
                end
                picks_due.push_back(pick);
            end
        endfunction

        function void match_pick(logic found, logic [TASK_W-1:0] next_task);
            t_pick due;
            if (picks_due.size() == 0) begin
                $error("unexpected result: found %0d, next_task %0d", found, next_task);
                faults++;
                return;
            end
            due = picks_due.pop_front();
            if (found !== due.found) begin
                $error("found: expected %0d, actual %0d", due.found, found);
                faults++;
            end
            if (next_task !== due.task_no) begin
                $error("next_task: expected %0d, actual %0d", due.task_no, next_task);
                faults++;
            end
        endfunction

        function int unsigned pending();
            return picks_due.size();
        endfunction

        function bit all_empty();
            return level_busy == '0;
        endfunction

        function int unsigned waiting_total();
            int unsigned sum;
            sum = 0;
            for (int t = 0; t < TASKS; t++) begin
                sum += (waiting_cnt[t] != 0) ? 1 : 0;
            end
            return sum;
        endfunction

        // Once every level is empty, tasks cut off by a repeated append are
        // gone for good, so the counts start afresh.
        function void forget_waiting();
            for (int t = 0; t < TASKS; t++) begin
                waiting_cnt[t] = 0;
            end
        endfunction
    endclass

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic [FUNC_W-1:0] i_func         = FUNC_READY;
    logic [TASK_W-1:0] i_task_id      = '0;
    logic [PRI_W-1:0]  i_priority_req = '0;
    logic              i_out_ready    = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_found;
    logic [TASK_W-1:0] o_next_task;

    ready_queue_shadow shadow;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       hold_asked     = 0;
    int unsigned       hold_taken     = 0;
    int unsigned       hold_left      = 0;
    logic [PRI_W-1:0]  hot_levels [4];

    priority_ready_queue_scheduler_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_task_id      (i_task_id),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_next_task    (o_next_task)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("priority_ready_queue_scheduler_top regression: fail");
        $finish;
    end

    // Receiver: checks each accepted result, then drives i_out_ready, low during a hold and random otherwise.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            shadow.match_pick(o_found, o_next_task);
        end
        if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one item, after a random gap, and notes it once it is accepted.
    task automatic send_item(logic [FUNC_W-1:0] func, logic [TASK_W-1:0] task_no,
                             logic [PRI_W-1:0] pri);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_task_id      <= task_no;
        i_priority_req <= pri;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shadow.take_request(func, task_no, pri);
    endtask

    task automatic send_random();
        int unsigned      busy;
        int unsigned      enq_pct;
        int unsigned      tries;
        logic [TASK_W-1:0] task_no;
        logic [PRI_W-1:0]  pri;
        busy    = shadow.waiting_total();
        enq_pct = (busy < 4) ? 80 : ((busy > 40) ? 30 : 55);
        if ($urandom_range(99) < enq_pct) begin
            task_no = TASK_W'($urandom_range(TASKS - 1));
            // Mostly a task that is not waiting yet; now and then a repeat.
            if ($urandom_range(99) >= 3) begin
                tries = 0;
                while (tries < 64 && shadow.waiting_cnt[task_no] != 0) begin
                    task_no = TASK_W'($urandom_range(TASKS - 1));
                    tries++;
                end
            end
            if ($urandom_range(1) == 1) begin
                pri = hot_levels[$urandom_range(3)];
            end else begin
                pri = PRI_W'($urandom_range(LEVELS - 1));
            end
            send_item(FUNC_READY, task_no, pri);
        end else begin
            send_item(FUNC_NEXT, TASK_W'($urandom), PRI_W'($urandom));
        end
    endtask

    task automatic drain_levels();
        while (!shadow.all_empty()) begin
            send_item(FUNC_NEXT, TASK_W'($urandom), PRI_W'($urandom));
        end
        send_item(FUNC_NEXT, TASK_W'($urandom), PRI_W'($urandom));
        shadow.forget_waiting();
    endtask

    initial begin
        shadow = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty pick, extremes of task and level, order within
        // one level, order across levels and a task appended twice.
        send_item(FUNC_NEXT, 6'd63, 5'd31);
        send_item(FUNC_READY, 6'd0, 5'd0);
        send_item(FUNC_READY, 6'd63, 5'd31);
        send_item(FUNC_READY, 6'd5, 5'd31);
        send_item(FUNC_READY, 6'd42, 5'd0);
        send_item(FUNC_NEXT, 6'd0, 5'd0);
        send_item(FUNC_NEXT, 6'd63, 5'd0);
        send_item(FUNC_NEXT, 6'd0, 5'd31);
        send_item(FUNC_NEXT, 6'd21, 5'd17);
        send_item(FUNC_NEXT, 6'd0, 5'd0);
        send_item(FUNC_READY, 6'd21, 5'd10);
        send_item(FUNC_READY, 6'd22, 5'd20);
        send_item(FUNC_READY, 6'd23, 5'd1);
        send_item(FUNC_NEXT, 6'd0, 5'd0);
        send_item(FUNC_NEXT, 6'd0, 5'd0);
        send_item(FUNC_NEXT, 6'd0, 5'd0);
        send_item(FUNC_READY, 6'd7, 5'd3);
        send_item(FUNC_READY, 6'd7, 5'd3);
        send_item(FUNC_NEXT, 6'd0, 5'd0);
        send_item(FUNC_NEXT, 6'd0, 5'd0);
        shadow.forget_waiting();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 60;
                end
                default: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                hot_levels[k] = PRI_W'($urandom_range(LEVELS - 1));
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // The receiver holds off while items keep being offered.
                if (ph == 0 && n == 60) begin
                    hold_asked++;
                end
                send_random();
            end
            drain_levels();
        end
        i_in_valid <= 1'b0;

        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (shadow.faults == 0 && shadow.pending() == 0) begin
            $display("priority_ready_queue_scheduler_top regression: pass");
        end else begin
            $display("priority_ready_queue_scheduler_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rqs_pkg.sv
hdl/rqs_ctrl.sv
hdl/rqs_dpath.sv
hdl/priority_ready_queue_scheduler_top.sv
test/tb.sv
